FILE: hw/rtl/mixed_fraction_adder_core_assert.svh
// Assertion macros for the mixed fraction adder.
// Included by modules that carry concurrent checks; no dependencies.
`ifndef MIXED_FRACTION_ADDER_CORE_ASSERT_SVH
`define MIXED_FRACTION_ADDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MFA_ASSERT_IMPL(label, ante, cons)
`define MFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/mfa_pkg.sv
// Package for the mixed fraction adder: payload structs, widths, sequencer states.
// No dependencies.
package mfa_pkg;
  localparam int OperandWidth = 15;
  localparam int ValWidth = 31;

  typedef struct packed {
    logic [OperandWidth-1:0] left_whole;
    logic [OperandWidth-1:0] left_numerator;
    logic [OperandWidth-1:0] left_denominator;
    logic [OperandWidth-1:0] right_whole;
    logic [OperandWidth-1:0] right_numerator;
    logic [OperandWidth-1:0] right_denominator;
  } operands_t;

  typedef struct packed {
    logic [16:0] sum_whole;
    logic [29:0] sum_numerator;
    logic [29:0] sum_denominator;
  } sum_t;

  typedef struct packed {
    logic start;
    logic [ValWidth-1:0] dividend;
    logic [ValWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [ValWidth-1:0] quotient;
    logic [ValWidth-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM_DIV, ST_NORM_DIVW,
    ST_GCD_STEP, ST_GCD_WAIT,
    ST_RED_NUM, ST_RED_NUMW, ST_RED_DEN, ST_RED_DENW,
    ST_LCM_DIV, ST_LCM_DIVW, ST_LCM_MUL,
    ST_SCALE_A, ST_SCALE_AW, ST_SCALE_B, ST_SCALE_BW,
    ST_MUL_A, ST_MUL_B, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_LEFT, PH_RIGHT, PH_LCM, PH_SUM
  } phase_t;
endpackage

FILE: hw/rtl/mixed_fraction_adder_core.sv
// Top level of the mixed fraction adder: sequencer around one shared divider.
// Depends on mfa_pkg, mfa_divider and mixed_fraction_adder_core_assert.svh.
//
// channel   signals                 direction  flow
// operands  start, busy, operands   in         taken when start && !busy
// sum       done, sum               out        one-cycle strobe, no stall
//
// Every division of a beat runs on the single shared divider as issue, one bit
// step per quotient bit, and done; the four Euclidean GCD loops (left, right,
// LCM and sum) dominate the time of a beat.
// busy rises the cycle after start and falls the cycle after done strobes.
// Reset clears the sequencer and the divider; data registers are not reset.
// The receiver cannot stall; the result is shown for exactly one cycle.
`include "mixed_fraction_adder_core_assert.svh"
module mixed_fraction_adder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mfa_pkg::operands_t operands,
  output logic               done,
  output mfa_pkg::sum_t      sum
);
  localparam int W = mfa_pkg::ValWidth;

  mfa_pkg::state_t state, state_next;
  mfa_pkg::phase_t phase;
  mfa_pkg::div_req_t dreq;
  mfa_pkg::div_rsp_t drsp;
  mfa_pkg::operands_t operands_r;

  logic [W-1:0] whole, num, den;   // operand under normalization
  logic [W-1:0] ga, gb;            // gcd working pair
  logic [W-1:0] aw, an, ad;        // normalized left
  logic [W-1:0] bw, bn, bd;        // normalized right
  logic [W-1:0] lcm, fa, fb, acc;
  logic [W-1:0] q_hold;

  mfa_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    state_next = state;
    dreq = '0;
    unique case (state)
      mfa_pkg::ST_IDLE: if (start) state_next = mfa_pkg::ST_NORM_DIV;
      mfa_pkg::ST_NORM_DIV: begin
        dreq = '{start: 1'b1, dividend: num, divisor: den};
        state_next = mfa_pkg::ST_NORM_DIVW;
      end
      mfa_pkg::ST_NORM_DIVW: if (drsp.done) state_next = mfa_pkg::ST_GCD_STEP;
      mfa_pkg::ST_GCD_STEP: begin
        if (ga == '0) begin
          state_next = (phase == mfa_pkg::PH_LCM) ? mfa_pkg::ST_LCM_DIV
                                                  : mfa_pkg::ST_RED_NUM;
        end else begin
          dreq = '{start: 1'b1, dividend: gb, divisor: ga};
          state_next = mfa_pkg::ST_GCD_WAIT;
        end
      end
      mfa_pkg::ST_GCD_WAIT: if (drsp.done) state_next = mfa_pkg::ST_GCD_STEP;
      mfa_pkg::ST_RED_NUM: begin
        dreq = '{start: 1'b1, dividend: num, divisor: gb};
        state_next = mfa_pkg::ST_RED_NUMW;
      end
      mfa_pkg::ST_RED_NUMW: if (drsp.done) state_next = mfa_pkg::ST_RED_DEN;
      mfa_pkg::ST_RED_DEN: begin
        dreq = '{start: 1'b1, dividend: den, divisor: gb};
        state_next = mfa_pkg::ST_RED_DENW;
      end
      mfa_pkg::ST_RED_DENW: begin
        if (drsp.done) begin
          unique case (phase)
            mfa_pkg::PH_LEFT: state_next = mfa_pkg::ST_NORM_DIV;
            mfa_pkg::PH_RIGHT: state_next = mfa_pkg::ST_GCD_STEP;
            default: state_next = mfa_pkg::ST_DONE;
          endcase
        end
      end
      mfa_pkg::ST_LCM_DIV: begin
        dreq = '{start: 1'b1, dividend: ad, divisor: gb};
        state_next = mfa_pkg::ST_LCM_DIVW;
      end
      mfa_pkg::ST_LCM_DIVW: if (drsp.done) state_next = mfa_pkg::ST_LCM_MUL;
      mfa_pkg::ST_LCM_MUL: state_next = mfa_pkg::ST_SCALE_A;
      mfa_pkg::ST_SCALE_A: begin
        dreq = '{start: 1'b1, dividend: lcm, divisor: ad};
        state_next = mfa_pkg::ST_SCALE_AW;
      end
      mfa_pkg::ST_SCALE_AW: if (drsp.done) state_next = mfa_pkg::ST_SCALE_B;
      mfa_pkg::ST_SCALE_B: begin
        dreq = '{start: 1'b1, dividend: lcm, divisor: bd};
        state_next = mfa_pkg::ST_SCALE_BW;
      end
      mfa_pkg::ST_SCALE_BW: if (drsp.done) state_next = mfa_pkg::ST_MUL_A;
      mfa_pkg::ST_MUL_A: state_next = mfa_pkg::ST_MUL_B;
      mfa_pkg::ST_MUL_B: state_next = mfa_pkg::ST_NORM_DIV;
      mfa_pkg::ST_DONE: state_next = mfa_pkg::ST_IDLE;
      default: state_next = mfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfa_pkg::ST_IDLE;
      phase <= mfa_pkg::PH_LEFT;
    end else begin
      state <= state_next;
      unique case (state)
        mfa_pkg::ST_IDLE: begin
          if (start) begin
            phase <= mfa_pkg::PH_LEFT;
            whole <= W'(operands.left_whole);
            num <= W'(operands.left_numerator);
            den <= (operands.left_denominator == '0) ? W'(1)
                                                     : W'(operands.left_denominator);
          end
        end
        mfa_pkg::ST_NORM_DIVW: begin
          if (drsp.done) begin
            whole <= whole + drsp.quotient;
            num <= drsp.remainder;
            ga <= drsp.remainder;
            gb <= den;
          end
        end
        mfa_pkg::ST_GCD_WAIT: begin
          if (drsp.done) begin
            gb <= ga;
            ga <= drsp.remainder;
          end
        end
        mfa_pkg::ST_RED_NUMW: if (drsp.done) q_hold <= drsp.quotient;
        mfa_pkg::ST_RED_DENW: begin
          if (drsp.done) begin
            unique case (phase)
              mfa_pkg::PH_LEFT: begin
                aw <= whole;
                an <= q_hold;
                ad <= drsp.quotient;
                phase <= mfa_pkg::PH_RIGHT;
                whole <= W'(operands_r.right_whole);
                num <= W'(operands_r.right_numerator);
                den <= (operands_r.right_denominator == '0) ? W'(1)
                                                         : W'(operands_r.right_denominator);
              end
              mfa_pkg::PH_RIGHT: begin
                bw <= whole;
                bn <= q_hold;
                bd <= drsp.quotient;
                phase <= mfa_pkg::PH_LCM;
                ga <= ad;
                gb <= drsp.quotient;
              end
              default: begin
                sum.sum_whole <= whole[16:0];
                sum.sum_numerator <= q_hold[29:0];
                sum.sum_denominator <= drsp.quotient[29:0];
              end
            endcase
          end
        end
        mfa_pkg::ST_LCM_DIVW: if (drsp.done) q_hold <= drsp.quotient;
        mfa_pkg::ST_LCM_MUL: lcm <= W'(32'(q_hold[15:0]) * 32'(bd[15:0]));
        mfa_pkg::ST_SCALE_AW: if (drsp.done) fa <= drsp.quotient;
        mfa_pkg::ST_SCALE_BW: if (drsp.done) fb <= drsp.quotient;
        mfa_pkg::ST_MUL_A: acc <= W'(32'(an[15:0]) * 32'(fa[15:0]));
        mfa_pkg::ST_MUL_B: begin
          num <= acc + W'(32'(bn[15:0]) * 32'(fb[15:0]));
          den <= lcm;
          whole <= aw + bw;
          phase <= mfa_pkg::PH_SUM;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfa_pkg::ST_IDLE && start) operands_r <= operands;
  end

  assign busy = (state != mfa_pkg::ST_IDLE);
  assign done = (state == mfa_pkg::ST_DONE);

  `MFA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `MFA_ASSERT_IMPL(a_done_busy, done, busy)
  `MFA_ASSERT_IMPL(a_den_nonzero, done, sum.sum_denominator != '0)
  `MFA_ASSERT_IMPL(a_proper, done, sum.sum_numerator < sum.sum_denominator)
endmodule

FILE: hw/rtl/mfa_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on mfa_pkg.
module mfa_divider (
  input  logic              clk,
  input  logic              rst,
  input  mfa_pkg::div_req_t req,
  output mfa_pkg::div_rsp_t rsp
);
  localparam int W = mfa_pkg::ValWidth;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] dvs;
  logic [CW-1:0] count;
  logic busy;
  logic done;
  logic [W:0] trial;

  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= CW'(W);
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem;
endmodule
